/* sv/sts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sorted key table with search, swap and
// insert.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int DEFAULT_KEY_BITS    = 32;

  // index field of the cell command is sized for the largest table
  localparam int MAX_IDX_W = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT
  } sts_state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SWAP
  } sts_op_e;

  typedef struct packed {
    sts_op_e              op;
    logic [MAX_IDX_W-1:0] pos;
  } sts_cmd_t;

endpackage
`default_nettype wire

/* sv/sts_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_cell
// One table entry. Takes its left neighbor on an insert shift, or trades
// with its neighbor on a swap.
// ----------------------------------------------------------------------------
module sts_cell #(
  parameter int IDX      = 0,
  parameter int KEY_BITS = sts_pkg::DEFAULT_KEY_BITS
) (
  input  wire logic                  clk_i,
  input  wire sts_pkg::sts_cmd_t     cmd_i,
  input  wire logic [KEY_BITS-1:0]   key_i,
  input  wire logic [KEY_BITS-1:0]   left_i,
  input  wire logic [KEY_BITS-1:0]   right_i,
  output logic      [KEY_BITS-1:0]   entry_o
);

  logic [KEY_BITS-1:0] entry_q;
  logic [KEY_BITS-1:0] entry_d;
  logic                at_pos;
  logic                above_pos;
  logic                next_pos;

  assign at_pos    = (cmd_i.pos == sts_pkg::MAX_IDX_W'(IDX));
  assign above_pos = (sts_pkg::MAX_IDX_W'(IDX) > cmd_i.pos);
  // this cell is the successor of the swap position
  assign next_pos  = (IDX > 0) && (cmd_i.pos == sts_pkg::MAX_IDX_W'(IDX - 1));

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      sts_pkg::OP_INSERT: begin
        if (at_pos) begin
          entry_d = key_i;
        end else if (above_pos) begin
          entry_d = left_i;
        end
      end
      sts_pkg::OP_SWAP: begin
        if (at_pos) begin
          entry_d = right_i;
        end else if (next_pos) begin
          entry_d = left_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

/* sv/sorted_table_search_swap_insert.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_search_swap_insert
// Sequence: accept a key while idle, binary search the table, then swap a
// hit with its successor if any, or insert a miss unless the table is full.
// Throughput: one key at a time, set by the probe loop (one entry read each
// cycle) and by output stalls; all cells take the insert shift at once.
// Reset: fill count and handshake state clear; entries are not reset.
// ----------------------------------------------------------------------------
module sorted_table_search_swap_insert #(
  parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH,
  parameter int KEY_BITS    = sts_pkg::DEFAULT_KEY_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] key
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o    // [0] found, [7:1] zero
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  sts_pkg::sts_state_e state_q, state_d;
  sts_pkg::sts_cmd_t   cmd;

  logic [CNT_W-1:0]           count_q, count_d;
  logic signed [CNT_W:0]      left_q, left_d;
  logic signed [CNT_W:0]      right_q, right_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic signed [KEY_BITS-1:0] key_in;
  logic                       res_found_q, res_found_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_found_q, out_found_d;

  logic signed [CNT_W+1:0]    mid_sum;
  logic [IDX_W-1:0]           mid;
  logic signed [CNT_W:0]      mid_s;
  logic signed [KEY_BITS-1:0] probe;
  logic                       slot_free;
  logic                       in_fire;
  logic                       has_next;
  logic                       full;

  logic [KEY_BITS-1:0] ent [TABLE_DEPTH];

  generate
    if (KEY_BITS <= 32) begin : g_key_narrow
      assign key_in = s_axis_tdata_i[KEY_BITS-1:0];
    end else begin : g_key_wide
      assign key_in = KEY_BITS'(signed'(s_axis_tdata_i));
    end
  endgenerate

  assign s_axis_tready_o = (state_q == sts_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign full            = (count_q == CNT_W'(TABLE_DEPTH));

  assign mid_sum  = (CNT_W+2)'(left_q) + (CNT_W+2)'(right_q);
  assign mid      = mid_sum[IDX_W:1];
  assign mid_s    = signed'((CNT_W+1)'(mid));
  assign probe    = signed'(ent[mid]);
  assign has_next = ((CNT_W+1)'(mid) + (CNT_W+1)'(1)) < (CNT_W+1)'(count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    left_d      = left_q;
    right_d     = right_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_found_d = out_found_q;
    cmd.op      = sts_pkg::OP_HOLD;
    cmd.pos     = '0;
    case (state_q)
      sts_pkg::ST_IDLE: begin
        if (in_fire) begin
          key_d   = key_in;
          left_d  = '0;
          right_d = signed'((CNT_W+1)'(count_q)) - (CNT_W+1)'(1);
          state_d = sts_pkg::ST_SEARCH;
        end
      end
      sts_pkg::ST_SEARCH: begin
        if (left_q > right_q) begin
          // miss: insert at the left bound unless the table is full
          if (!full) begin
            cmd.op  = sts_pkg::OP_INSERT;
            cmd.pos = sts_pkg::MAX_IDX_W'(left_q[IDX_W-1:0]);
            count_d = count_q + CNT_W'(1);
          end
          res_found_d = 1'b0;
          state_d     = sts_pkg::ST_WAIT;
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_found_d = 1'b0;
            state_d     = sts_pkg::ST_IDLE;
          end
        end else if (key_q == probe) begin
          if (has_next) begin
            cmd.op  = sts_pkg::OP_SWAP;
            cmd.pos = sts_pkg::MAX_IDX_W'(mid);
          end
          res_found_d = 1'b1;
          state_d     = sts_pkg::ST_WAIT;
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_found_d = 1'b1;
            state_d     = sts_pkg::ST_IDLE;
          end
        end else if (key_q < probe) begin
          right_d = mid_s - (CNT_W+1)'(1);
        end else begin
          left_d = mid_s + (CNT_W+1)'(1);
        end
      end
      sts_pkg::ST_WAIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          state_d     = sts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sts_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q      <= left_d;
    right_q     <= right_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    out_found_q <= out_found_d;
  end

  generate
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0] left_nb;
      logic [KEY_BITS-1:0] right_nb;
      if (g == 0) begin : g_first
        assign left_nb = key_q;
      end else begin : g_mid_l
        assign left_nb = ent[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_last
        assign right_nb = ent[g];
      end else begin : g_mid_r
        assign right_nb = ent[g+1];
      end
      sts_cell #(
        .IDX      (g),
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk_i   (clk_i),
        .cmd_i   (cmd),
        .key_i   (key_q),
        .left_i  (left_nb),
        .right_i (right_nb),
        .entry_o (ent[g])
      );
    end
  endgenerate

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_found_q};

endmodule
`default_nettype wire
